// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk with active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds on every active edge
`define CHK_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed: condition");
// antecedent implies consequent on the same edge
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: implication");
`else
`define CHK_ALWAYS(lbl, cond)
`define CHK_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/tbrs_pkg.sv =====
`timescale 1ns / 1ps
package tbrs_pkg;

    localparam int DELTA_W   = 17;
    localparam int RANGE_W   = 17;
    localparam int SQ_W      = 34;
    localparam int ISQ_STEPS = 17;
    localparam int REM_W     = 21;
    localparam int XW        = 44;
    localparam int ZW        = 32;
    localparam int DIV_QW    = 17;
    localparam int DIV_RW    = 33;
    localparam int DIV_LAT   = DIV_QW + 1;
    localparam int ATAN_LEN  = 24;

    localparam logic [15:0] ONE_Q15  = 16'h8000;
    localparam logic [16:0] MIN_FOV2 = 17'd21;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_DIAG = 2'd1,
        CFG_FOV  = 2'd2
    } cfg_idx_t;

    // one queued word: delta, heading and zero flag
    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic        [15:0]        hd;
        logic                      zero;
    } tbrs_item_t;

    typedef struct packed {
        logic       valid;
        tbrs_item_t data;
    } tbrs_q_t;

    // carried alongside the CORDIC and root steps
    typedef struct packed {
        logic        zero;
        logic        dx_pos;
        logic        dy_pos;
        logic [15:0] hd;
        logic [15:0] adx;
        logic [15:0] ady;
    } tbrs_step_t;

    // carried alongside the dividers
    typedef struct packed {
        logic              mode;
        logic              zero;
        logic              dx_pos;
        logic              dy_pos;
        logic              vis;
        logic              b_pos;
        logic [15:0]       bearing;
        logic [RANGE_W-1:0] range;
    } tbrs_side_t;

    function automatic logic [ZW-1:0] atan_entry(input int unsigned k);
        logic [ZW-1:0] v;
        case (k)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tbrs_if.sv =====
`timescale 1ns / 1ps
interface tbrs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] agent_x;
    logic signed [15:0] agent_y;
    logic signed [15:0] agent_heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;

    modport source (output valid, agent_x, agent_y, agent_heading, target_x, target_y,
                    input ready);
    modport sink   (input valid, agent_x, agent_y, agent_heading, target_x, target_y,
                    output ready);
endinterface

interface tbrs_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] sense_a;
    logic        [15:0] sense_b;
    logic        [15:0] sense_c;
    logic        [15:0] sense_d;
    logic        [15:0] sense_e;
    logic               target_visible;
    logic signed [15:0] bearing;
    logic        [16:0] range;

    modport source (output valid, sense_a, sense_b, sense_c, sense_d, sense_e,
                    target_visible, bearing, range, input ready);
    modport sink   (input valid, sense_a, sense_b, sense_c, sense_d, sense_e,
                    target_visible, bearing, range, output ready);
endinterface

// ===== hw/rtl/tbrs_front.sv =====
`timescale 1ns / 1ps
module tbrs_front (
    tbrs_in_if.sink             req,
    input  logic                full,
    output logic                push,
    output tbrs_pkg::tbrs_item_t item
);
    import tbrs_pkg::*;

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;

    assign dx = DELTA_W'(req.target_x) - DELTA_W'(req.agent_x);
    assign dy = DELTA_W'(req.target_y) - DELTA_W'(req.agent_y);

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        item.dx   = dx;
        item.dy   = dy;
        item.hd   = req.agent_heading;
        item.zero = (dx == '0) && (dy == '0);
    end
endmodule

// ===== hw/rtl/tbrs_queue.sv =====
`timescale 1ns / 1ps
module tbrs_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tbrs_pkg::tbrs_item_t item,
    input  logic                 pop,
    output tbrs_pkg::tbrs_q_t    q,
    output logic                 full
);
    import tbrs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tbrs_item_t      mem [0:DEPTH-1];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_pop;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign do_pop = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CW'(push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= item;
    end

    assign q.valid = (cnt_reg != '0);
    assign q.data  = mem[rd_ptr_reg];
endmodule

// ===== hw/rtl/tbrs_div.sv =====
`timescale 1ns / 1ps
// round(num*32768/den) saturated at 1.0, one quotient bit per stage
module tbrs_div (
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] num,
    input  logic [16:0] den,
    output logic [15:0] quo
);
    import tbrs_pkg::*;

    logic [DIV_RW-1:0] rem_reg [0:DIV_QW];
    logic [DIV_QW-1:0] q_reg   [0:DIV_QW];
    logic [16:0]       den_reg [0:DIV_QW];
    logic              ovf_reg [0:DIV_QW];

    logic [DIV_RW-1:0] dvd;
    assign dvd = {1'b0, num, 15'b0} + DIV_RW'(den >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dvd;
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ({1'b0, dvd} >= {den, 17'b0});
        end
    end

    for (genvar i = 0; i < DIV_QW; i++)
    begin : g_step
        localparam int J = DIV_QW - 1 - i;
        logic [DIV_RW:0]   dv;
        logic              ge;
        logic [DIV_RW-1:0] rem_next;
        logic [DIV_QW-1:0] q_next;

        always_comb
        begin
            dv       = (DIV_RW + 1)'(den_reg[i]) << J;
            ge       = ({1'b0, rem_reg[i]} >= dv);
            rem_next = ge ? rem_reg[i] - dv[DIV_RW-1:0] : rem_reg[i];
            q_next   = q_reg[i];
            q_next[J] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= rem_next;
                q_reg[i+1]   <= q_next;
                den_reg[i+1] <= den_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    assign quo = (ovf_reg[DIV_QW] || (q_reg[DIV_QW] > DIV_QW'(ONE_Q15)))
               ? ONE_Q15 : q_reg[DIV_QW][15:0];
endmodule

// ===== hw/rtl/tbrs_back.sv =====
`timescale 1ns / 1ps
module tbrs_back #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbrs_pkg::tbrs_q_t q,
    output logic              pop,
    input  logic              mode,
    input  logic [16:0]       diag_len,
    input  logic [15:0]       fov_width,
    tbrs_out_if.source        rsp
);
    import tbrs_pkg::*;

    localparam int NSTEP = (CORDIC_STAGES > ISQ_STEPS) ? CORDIC_STAGES : ISQ_STEPS;

    logic en;
    logic out_vld_reg;

    assign en  = !out_vld_reg || rsp.ready;
    assign pop = en && q.valid;

    // stage A: squares
    logic                      a_vld_reg;
    logic [SQ_W-1:0]           a_sqx_reg, a_sqy_reg;
    logic signed [DELTA_W-1:0] a_dx_reg, a_dy_reg;
    tbrs_step_t                a_st_reg;
    logic [16:0]               adx, ady;

    always_comb
    begin
        adx = q.data.dx[DELTA_W-1] ? 17'(-q.data.dx) : 17'(q.data.dx);
        ady = q.data.dy[DELTA_W-1] ? 17'(-q.data.dy) : 17'(q.data.dy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sqx_reg       <= adx * adx;
            a_sqy_reg       <= ady * ady;
            a_dx_reg        <= q.data.dx;
            a_dy_reg        <= q.data.dy;
            a_st_reg.zero   <= q.data.zero;
            a_st_reg.dx_pos <= !q.data.dx[DELTA_W-1] && (q.data.dx != '0);
            a_st_reg.dy_pos <= !q.data.dy[DELTA_W-1] && (q.data.dy != '0);
            a_st_reg.hd     <= q.data.hd;
            a_st_reg.adx    <= adx[15:0];
            a_st_reg.ady    <= ady[15:0];
        end
    end

    // step pipeline: root digits and CORDIC rotations in lockstep
    logic                 s_vld_reg  [0:NSTEP];
    logic [SQ_W-1:0]      s_sq_reg   [0:NSTEP];
    logic [REM_W-1:0]     s_rem_reg  [0:NSTEP];
    logic [RANGE_W-1:0]   s_root_reg [0:NSTEP];
    logic signed [XW-1:0] s_x_reg    [0:NSTEP];
    logic signed [XW-1:0] s_y_reg    [0:NSTEP];
    logic [ZW-1:0]        s_z_reg    [0:NSTEP];
    tbrs_step_t           s_st_reg   [0:NSTEP];

    logic signed [XW-1:0] x0, y0;
    assign x0 = XW'(a_dx_reg) <<< 24;
    assign y0 = XW'(a_dy_reg) <<< 24;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_sq_reg[0]   <= a_sqx_reg + a_sqy_reg;
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
            s_x_reg[0]    <= a_dx_reg[DELTA_W-1] ? -x0 : x0;
            s_y_reg[0]    <= a_dx_reg[DELTA_W-1] ? -y0 : y0;
            s_z_reg[0]    <= a_dx_reg[DELTA_W-1] ? 32'h80000000 : 32'h0;
            s_st_reg[0]   <= a_st_reg;
        end
    end

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        logic [REM_W-1:0]     rem_next;
        logic [RANGE_W-1:0]   root_next;
        logic signed [XW-1:0] x_next, y_next;
        logic [ZW-1:0]        z_next;

        if (k < ISQ_STEPS)
        begin : g_root
            logic [REM_W-1:0] tr, tt;
            always_comb
            begin
                tr = {s_rem_reg[k][REM_W-3:0], s_sq_reg[k][2*(ISQ_STEPS-1-k)+1 -: 2]};
                tt = {2'b00, s_root_reg[k], 2'b01};
                if (tr >= tt)
                begin
                    rem_next  = tr - tt;
                    root_next = {s_root_reg[k][RANGE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = tr;
                    root_next = {s_root_reg[k][RANGE_W-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_root_hold
            assign rem_next  = s_rem_reg[k];
            assign root_next = s_root_reg[k];
        end

        if (k < CORDIC_STAGES)
        begin : g_rot
            logic signed [XW-1:0] xs, ys;
            logic                 ypos;
            always_comb
            begin
                xs   = s_x_reg[k] >>> k;
                ys   = s_y_reg[k] >>> k;
                ypos = !s_y_reg[k][XW-1] && (s_y_reg[k] != '0);
                if (ypos)
                begin
                    x_next = s_x_reg[k] + ys;
                    y_next = s_y_reg[k] - xs;
                    z_next = s_z_reg[k] + atan_entry(k);
                end
                else
                begin
                    x_next = s_x_reg[k] - ys;
                    y_next = s_y_reg[k] + xs;
                    z_next = s_z_reg[k] - atan_entry(k);
                end
            end
        end
        else
        begin : g_rot_hold
            assign x_next = s_x_reg[k];
            assign y_next = s_y_reg[k];
            assign z_next = s_z_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_sq_reg[k+1]   <= s_sq_reg[k];
                s_rem_reg[k+1]  <= rem_next;
                s_root_reg[k+1] <= root_next;
                s_x_reg[k+1]    <= x_next;
                s_y_reg[k+1]    <= y_next;
                s_z_reg[k+1]    <= z_next;
                s_st_reg[k+1]   <= s_st_reg[k];
            end
        end
    end

    // stage R: rounding, bearing, visibility, divider operands
    tbrs_step_t          fin;
    logic [RANGE_W-1:0]  range_c;
    logic [ZW-1:0]       z_rnd;
    logic [15:0]         bu;
    logic signed [16:0]  bse;
    logic [16:0]         mag, mag2, h2;
    tbrs_side_t          side_c;

    always_comb
    begin
        fin     = s_st_reg[NSTEP];
        range_c = s_root_reg[NSTEP] +
                  RANGE_W'(s_rem_reg[NSTEP] > REM_W'(s_root_reg[NSTEP]));
        z_rnd   = s_z_reg[NSTEP] + 32'h8000;
        bu      = fin.zero ? 16'h0 : z_rnd[31:16] - fin.hd;
        bse     = {bu[15], bu};
        mag     = bse[16] ? 17'(-bse) : 17'(bse);
        mag2    = {mag[15:0], 1'b0};
        h2      = ({1'b0, fov_width} < MIN_FOV2) ? MIN_FOV2 : {1'b0, fov_width};
        side_c.mode    = mode;
        side_c.zero    = fin.zero;
        side_c.dx_pos  = fin.dx_pos;
        side_c.dy_pos  = fin.dy_pos;
        side_c.vis     = (mag2 <= h2);
        side_c.b_pos   = !bse[16] && (bse != '0);
        side_c.bearing = bu;
        side_c.range   = range_c;
    end

    logic        r_vld_reg;
    logic [16:0] r_na_reg, r_da_reg, r_nb_reg, r_db_reg, r_dc_reg;
    tbrs_side_t  side_reg [0:DIV_LAT];
    logic        d_vld_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_na_reg    <= mode ? mag2 : {1'b0, fin.adx};
            r_da_reg    <= mode ? h2 : range_c;
            r_nb_reg    <= {1'b0, fin.ady};
            r_db_reg    <= range_c;
            r_dc_reg    <= diag_len;
            side_reg[0] <= side_c;
        end
    end

    for (genvar j = 0; j < DIV_LAT; j++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[j+1] <= side_reg[j];
        end
    end

    logic [15:0] qa, qb, qc;

    tbrs_div u_div_a (.clk(clk), .en(en), .num(r_na_reg), .den(r_da_reg), .quo(qa));
    tbrs_div u_div_b (.clk(clk), .en(en), .num(r_nb_reg), .den(r_db_reg), .quo(qb));
    tbrs_div u_div_c (.clk(clk), .en(en), .num(side_reg[0].range), .den(r_dc_reg),
                      .quo(qc));

    // valid chain; d_vld_reg[i] travels with side_reg[i+1]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            r_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i <= NSTEP; i++)
                s_vld_reg[i] <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
                d_vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg    <= q.valid;
            s_vld_reg[0] <= a_vld_reg;
            for (int i = 0; i < NSTEP; i++)
                s_vld_reg[i+1] <= s_vld_reg[i];
            r_vld_reg    <= s_vld_reg[NSTEP];
            d_vld_reg[0] <= r_vld_reg;
            for (int i = 0; i < DIV_LAT - 1; i++)
                d_vld_reg[i+1] <= d_vld_reg[i];
            out_vld_reg  <= d_vld_reg[DIV_LAT-1];
        end
    end

    // output encoding
    tbrs_side_t  so;
    logic [15:0] nd, a_c, b_c, c_c, d_c, e_c;
    logic        vis_c;

    always_comb
    begin
        so    = side_reg[DIV_LAT];
        nd    = (so.range == '0) ? 16'h0 : qc;
        a_c   = '0;
        b_c   = '0;
        c_c   = '0;
        d_c   = '0;
        e_c   = '0;
        vis_c = 1'b1;
        if (!so.mode)
        begin
            if (!so.zero)
            begin
                if (so.dx_pos) a_c = qa; else b_c = qa;
                if (so.dy_pos) c_c = qb; else d_c = qb;
            end
            e_c = nd;
        end
        else
        begin
            vis_c = so.vis;
            if (so.vis)
            begin
                a_c = ONE_Q15;
                if (so.b_pos) b_c = qa; else c_c = qa;
                d_c = nd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp.sense_a        <= a_c;
            rsp.sense_b        <= b_c;
            rsp.sense_c        <= c_c;
            rsp.sense_d        <= d_c;
            rsp.sense_e        <= e_c;
            rsp.target_visible <= vis_c;
            rsp.bearing        <= so.bearing;
            rsp.range          <= so.range;
        end
    end

    assign rsp.valid = out_vld_reg;
endmodule

// ===== hw/rtl/target_bearing_range_sensor_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake     words
// req       in   valid/ready   agent_x, agent_y, agent_heading, target_x, target_y
// rsp       out  valid/ready   sense_a..sense_e, target_visible, bearing, range
// cfg       in   cfg_we        cfg_index, cfg_wdata (no read-back)
//
// One word per cycle sustained while rsp.ready stays high; the path from acceptance to
// rsp.valid runs through the 17-digit root steps / CORDIC rotations, followed by
// the 17-step restoring dividers.
// Reset: async, active low; clears handshake state and loads register defaults.
// Stalls: rsp.ready low while rsp.valid is high freezes the whole back pipeline; the front queue keeps
// taking words until it holds QUEUE_DEPTH of them.
`include "assert_macros.svh"
module target_bearing_range_sensor_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    tbrs_in_if.sink     req,
    tbrs_out_if.source  rsp
);
    import tbrs_pkg::*;

    // configuration registers
    logic        sense_mode_reg;
    logic [16:0] diag_len_reg;
    logic [15:0] fov_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_mode_reg <= 1'b0;
            diag_len_reg   <= 17'd16384;
            fov_width_reg  <= 16'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE: sense_mode_reg <= cfg_wdata[0];
                CFG_DIAG: diag_len_reg   <= cfg_wdata;
                CFG_FOV:  fov_width_reg  <= cfg_wdata[15:0];
                default:  ; // unmapped index, dropped
            endcase
        end
    end

    // front: delta and zero test, straight into the queue
    tbrs_item_t item;
    logic       push;
    logic       full;
    tbrs_q_t    q;
    logic       pop;

    tbrs_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (item)
    );

    tbrs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .pop   (pop),
        .q     (q),
        .full  (full)
    );

    // back: squares, root + CORDIC steps, dividers, output register
    tbrs_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .mode      (sense_mode_reg),
        .diag_len  (diag_len_reg),
        .fov_width (fov_width_reg),
        .rsp       (rsp)
    );

    // all four shares clear
    logic shares_zero;
    assign shares_zero = (rsp.sense_a == 16'h0) && (rsp.sense_b == 16'h0) &&
                         (rsp.sense_c == 16'h0) && (rsp.sense_d == 16'h0);

    // vector mode always reports the target as visible
    `CHK_IMPLY(a_vec_visible, rsp.valid && !sense_mode_reg, rsp.target_visible)
    // field-of-view mode never drives the fifth share
    `CHK_IMPLY(a_fov_e_zero, rsp.valid && sense_mode_reg, rsp.sense_e == 16'h0)
    // hidden target in field-of-view mode gives all-zero shares
    `CHK_IMPLY(a_fov_hidden, rsp.valid && sense_mode_reg && !rsp.target_visible, shares_zero)
endmodule
